>>> design/assert_macros.svh
// Assertion macros shared by the keypad auto-repeat design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define KPAR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition, once seen, is followed by another in the next cycle.
`define KPAR_ASSERT_NEXT(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

>>> design/kpar_pkg.sv
// Package with widths, codes, reset values and helpers for the keypad auto-repeat block.
`default_nettype none
package kpar_pkg;

   localparam int unsigned KEY_COUNT   = 16;
   localparam int unsigned KEY_IDX_W   = 4;
   localparam int unsigned TIME_W      = 32;
   localparam int unsigned SPAN_W      = 8;
   localparam int unsigned PLAYER_OFS  = 4;

   localparam int unsigned REQ_DATA_W  = 56;
   localparam int unsigned REQ_USER_W  = 2;
   localparam int unsigned RSP_DATA_W  = 8;
   localparam int unsigned CSR_IDX_W   = 1;
   localparam int unsigned CSR_DATA_W  = 8;

   localparam logic [SPAN_W-1:0] FIRST_DELAY_RESET = 8'd20;
   localparam logic [SPAN_W-1:0] REPEAT_INT_RESET  = 8'd5;

   typedef enum logic [REQ_USER_W-1:0] {
      KIND_SCAN = 2'd0,
      KIND_POLL = 2'd1,
      KIND_HELD = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FIRST_DELAY = 1'b0,
      CSR_REPEAT_INT  = 1'b1
   } csr_index_type;

   typedef logic [KEY_COUNT-1:0] keys_type;

   typedef struct packed {
      logic                 held;
      logic [KEY_IDX_W-1:0] key_code;
      logic                 pressed;
   } result_type;

   // Index of the lowest set bit, zero when none is set.
   function automatic logic [KEY_IDX_W-1:0] lowest_index(input keys_type v);
      logic [KEY_IDX_W-1:0] idx;
      idx = '0;
      for (int i = KEY_COUNT - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = KEY_IDX_W'(i);
         end
      end
      return idx;
   endfunction

endpackage
`default_nettype wire

>>> design/keypad_press_auto_repeat.sv
// Top level of the keypad qualifier: scan, poll with auto-repeat, and held query.
//
// Requests enter on req_ (tuser = kind, tdata = key vector, frame count, key index,
// player). Every request yields exactly one response on rsp_ (pressed, key code,
// held). A scan stores a new held-key vector and answers all zero; a poll reports
// the lowest newly pressed key or a repeat of the key kept held; a held query
// tells whether a key is down and not locked.
// A request is registered on acceptance, processed against the key state once the
// response register can advance, and written to the response register, which drives
// rsp_tvalid. One request per cycle is taken while the receiver does not stall, set
// by the single input register feeding the response register.
// When the receiver stalls, the response register holds and the input register
// still takes one more request; further requests wait on req_tready.
// Reset clears all key state, the delay registers return to 20 and 5 frames, and
// no response is pending. Write csr_ only while no request is in flight.
`default_nettype none
`include "assert_macros.svh"
module keypad_press_auto_repeat (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   // [15:0] key_vector, [47:16] frame_count, [51:48] key_index, [52] player, rest 0
   input  wire logic [kpar_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [1:0] kind
   input  wire logic [kpar_pkg::REQ_USER_W-1:0]     req_tuser,
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [0] pressed, [4:1] key_code, [5] held, [7:6] 0
   output      logic [kpar_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  wire logic                                csr_valid,
   output      logic                                csr_ready,
   input  wire logic [kpar_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [kpar_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic                                 in_valid_ff;
   logic [kpar_pkg::REQ_DATA_W-1:0]      in_data_ff;
   logic [kpar_pkg::REQ_USER_W-1:0]      in_kind_ff;
   logic                                 rsp_valid_ff;
   kpar_pkg::result_type                 rsp_ff, rsp_in;

   logic [kpar_pkg::SPAN_W-1:0]          first_delay_ff, repeat_int_ff;
   kpar_pkg::keys_type                   keys_now_ff, keys_now_in;
   kpar_pkg::keys_type                   keys_before_ff, keys_before_in;
   kpar_pkg::keys_type                   keys_locked_ff, keys_locked_in;
   kpar_pkg::keys_type                   repeat_key_ff, repeat_key_in;
   logic [kpar_pkg::TIME_W-1:0]          last_time_ff, last_time_in;
   logic [kpar_pkg::SPAN_W-1:0]          span_ff, span_in;

   logic                                 advance;
   logic                                 process;

   kpar_pkg::keys_type                   vec;
   logic [kpar_pkg::TIME_W-1:0]          now_t;
   logic [kpar_pkg::KEY_IDX_W-1:0]       key_idx;
   logic                                 player;
   logic [kpar_pkg::TIME_W-1:0]          deadline;
   kpar_pkg::keys_type                   before_armed, fresh, diff, pick, pick_low;
   kpar_pkg::keys_type                   avail;
   logic [kpar_pkg::KEY_IDX_W:0]         held_idx;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign process    = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(kpar_pkg::RSP_DATA_W - $bits(kpar_pkg::result_type)){1'b0}}, rsp_ff};

   assign vec     = in_data_ff[15:0];
   assign now_t   = in_data_ff[47:16];
   assign key_idx = in_data_ff[51:48];
   assign player  = in_data_ff[52];

   always_comb begin
      keys_now_in    = keys_now_ff;
      keys_before_in = keys_before_ff;
      keys_locked_in = keys_locked_ff;
      repeat_key_in  = repeat_key_ff;
      last_time_in   = last_time_ff;
      span_in        = span_ff;
      rsp_in         = '0;

      deadline     = last_time_ff + kpar_pkg::TIME_W'(span_ff);
      before_armed = (now_t >= deadline) ? (keys_before_ff & ~repeat_key_ff) : keys_before_ff;
      fresh        = keys_now_ff & ~before_armed;
      diff         = fresh & ~repeat_key_ff;
      pick         = (diff != '0) ? diff : repeat_key_ff;
      pick_low     = pick & (~pick + kpar_pkg::KEY_COUNT'(1));
      avail        = keys_now_ff & ~keys_locked_ff;
      held_idx     = {1'b0, key_idx}
                     + (player ? (kpar_pkg::KEY_IDX_W + 1)'(kpar_pkg::PLAYER_OFS)
                               : (kpar_pkg::KEY_IDX_W + 1)'(0));

      case (in_kind_ff)
         kpar_pkg::KIND_SCAN: begin
            keys_before_in = keys_now_ff;
            keys_now_in    = vec;
            keys_locked_in = keys_locked_ff & ~(keys_now_ff ^ vec);
            repeat_key_in  = repeat_key_ff & keys_locked_in;
         end
         kpar_pkg::KIND_POLL: begin
            keys_before_in = before_armed;
            if (fresh != '0) begin
               keys_locked_in  = keys_locked_ff | pick;
               last_time_in    = now_t;
               span_in         = (pick != repeat_key_ff) ? first_delay_ff : repeat_int_ff;
               repeat_key_in   = pick_low;
               rsp_in.pressed  = 1'b1;
               rsp_in.key_code = kpar_pkg::lowest_index(pick_low);
            end
         end
         kpar_pkg::KIND_HELD: begin
            rsp_in.held = !held_idx[kpar_pkg::KEY_IDX_W]
                          && avail[held_idx[kpar_pkg::KEY_IDX_W-1:0]];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         keys_now_ff    <= '0;
         keys_before_ff <= '0;
         keys_locked_ff <= '0;
         repeat_key_ff  <= '0;
         last_time_ff   <= '0;
         span_ff        <= '0;
         first_delay_ff <= kpar_pkg::FIRST_DELAY_RESET;
         repeat_int_ff  <= kpar_pkg::REPEAT_INT_RESET;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (process) begin
            keys_now_ff    <= keys_now_in;
            keys_before_ff <= keys_before_in;
            keys_locked_ff <= keys_locked_in;
            repeat_key_ff  <= repeat_key_in;
            last_time_ff   <= last_time_in;
            span_ff        <= span_in;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               kpar_pkg::CSR_FIRST_DELAY: first_delay_ff <= csr_wdata;
               kpar_pkg::CSR_REPEAT_INT:  repeat_int_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
         in_kind_ff <= req_tuser;
      end
      if (process) begin
         rsp_ff <= rsp_in;
      end
   end

   `KPAR_ASSERT(a_repeat_onehot, $onehot0(repeat_key_ff), "repeat key has more than one bit")
   `KPAR_ASSERT(a_locked_held, (keys_locked_ff & ~keys_now_ff) == '0, "locked key not held")
   `KPAR_ASSERT(a_repeat_locked, (repeat_key_ff & ~keys_locked_ff) == '0, "repeat key not locked")
   `KPAR_ASSERT_NEXT(a_stall_keeps, in_valid_ff && !advance, in_valid_ff, "request lost")

endmodule
`default_nettype wire

>>> test/keypad_press_auto_repeat_tb.sv
// Self-checking testbench for the keypad qualifier: scans, polls and held queries under random flow control.
module keypad_press_auto_repeat_tb;
   import kpar_pkg::*;

   localparam logic [REQ_USER_W-1:0] KIND_UNUSED = 2'd3;

   typedef struct {
      logic [REQ_USER_W-1:0] kind;
      keys_type              vector;
      logic [TIME_W-1:0]     frame;
      logic [KEY_IDX_W-1:0]  index;
      logic                  player;
   } keypad_req_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // key state mirror
   keys_type            keys_down   = '0;
   keys_type            keys_prev   = '0;
   keys_type            keys_lock   = '0;
   keys_type            repeat_bit  = '0;
   logic [TIME_W-1:0]   press_stamp = '0;
   logic [SPAN_W-1:0]   span_now    = '0;
   logic [SPAN_W-1:0]   cfg_first_delay = FIRST_DELAY_RESET;
   logic [SPAN_W-1:0]   cfg_repeat_int  = REPEAT_INT_RESET;

   keypad_req_type      pending_reqs[$];
   keypad_req_type      on_wire;
   result_type          awaited_answers[$];

   keys_type            held_keys   = '0;
   logic [TIME_W-1:0]   frame_clock = '0;
   int                  send_idle_pct = 0;
   int                  rsp_stall_pct = 0;
   int                  errors     = 0;
   int                  accepted   = 0;
   int                  presses    = 0;
   int                  held_hits  = 0;
   int                  csr_writes = 0;

   keypad_press_auto_repeat i_dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic result_type predict_answer(input keypad_req_type r);
      result_type        res;
      keys_type          fresh;
      keys_type          pick;
      logic [TIME_W-1:0] deadline;
      logic [31:0]       probe;
      res = '0;
      case (r.kind)
         KIND_SCAN: begin
            keys_prev = keys_down;
            keys_down = r.vector;
            keys_lock &= ~(keys_prev ^ keys_down);
            repeat_bit &= keys_lock;
         end
         KIND_POLL: begin
            deadline = press_stamp + TIME_W'(span_now);
            if (r.frame >= deadline) begin
               keys_prev &= ~repeat_bit;
            end
            fresh = keys_down & ~keys_prev;
            if (fresh != '0) begin
               pick = ((fresh & ~repeat_bit) != '0) ? (fresh & ~repeat_bit) : repeat_bit;
               keys_lock |= pick;
               press_stamp = r.frame;
               span_now = (pick != repeat_bit) ? cfg_first_delay : cfg_repeat_int;
               repeat_bit = pick & (~pick + 1'b1);
               res.pressed = 1'b1;
               for (int i = KEY_COUNT - 1; i >= 0; i--) begin
                  if (repeat_bit[i]) begin
                     res.key_code = KEY_IDX_W'(i);
                  end
               end
            end
         end
         KIND_HELD: begin
            // bits past the top key read as zero
            probe = (r.player ? 32'h10 : 32'h01) << r.index;
            res.held = |(probe[KEY_COUNT-1:0] & keys_down & ~keys_lock);
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            awaited_answers.push_back(predict_answer(on_wire));
            accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               on_wire = pending_reqs.pop_front();
               req_tdata <= REQ_DATA_W'({on_wire.player, on_wire.index, on_wire.frame,
                                         on_wire.vector});
               req_tuser <= on_wire.kind;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[$bits(result_type)-1:0]);
            if (awaited_answers.size() == 0) begin
               $display("%0t: response %h with none expected", $time, rsp_tdata);
               errors++;
            end else begin
               want = awaited_answers.pop_front();
               check_field("pressed", want.pressed, got.pressed);
               check_field("key_code", want.key_code, got.key_code);
               check_field("held", want.held, got.held);
               presses += want.pressed;
               held_hits += want.held;
            end
         end
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic push_req(input logic [REQ_USER_W-1:0] kind, input keys_type vector,
                           input logic [TIME_W-1:0] frame, input logic [KEY_IDX_W-1:0] index,
                           input logic player);
      keypad_req_type r;
      r.kind = kind;
      r.vector = vector;
      r.frame = frame;
      r.index = index;
      r.player = player;
      pending_reqs.push_back(r);
   endtask

   task automatic queue_session(input int count);
      keypad_req_type r;
      int             roll;
      int             step;
      for (int n = 0; n < count; n++) begin
         r.kind = KIND_HELD;
         r.vector = KEY_COUNT'($urandom);
         r.frame = $urandom;
         r.index = KEY_IDX_W'($urandom);
         r.player = 1'($urandom);
         roll = $urandom_range(99);
         if (roll < 4) begin
            r.kind = REQ_USER_W'($urandom);
         end else if (roll < 30) begin
            r.kind = KIND_SCAN;
            case ($urandom_range(9))
               0, 1, 2, 3: r.vector = held_keys;
               4, 5, 6:    r.vector = held_keys ^ (16'h1 << $urandom_range(15));
               7:          r.vector = '0;
               default:    ;
            endcase
            held_keys = r.vector;
         end else if (roll < 75) begin
            r.kind = KIND_POLL;
            step = ((cfg_first_delay > cfg_repeat_int) ? cfg_first_delay : cfg_repeat_int) / 4
                   + 3;
            case ($urandom_range(19))
               0:       frame_clock = $urandom;
               1:       frame_clock = 32'hFFFF_FFFF - $urandom_range(40);
               default: frame_clock += $urandom_range(step);
            endcase
            r.frame = frame_clock;
         end
         pending_reqs.push_back(r);
      end
   endtask

   task automatic drain();
      while (pending_reqs.size() != 0 || awaited_answers.size() != 0 || req_tvalid) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_FIRST_DELAY) begin
         cfg_first_delay = value;
      end else begin
         cfg_repeat_int = value;
      end
      csr_writes++;
   endtask

   task automatic run_phase(input logic [SPAN_W-1:0] first_delay,
                            input logic [SPAN_W-1:0] interval,
                            input int send_pct, input int stall_pct, input int count);
      drain();
      write_csr(CSR_FIRST_DELAY, first_delay);
      write_csr(CSR_REPEAT_INT, interval);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      queue_session(count / 2);
      // hold the sender until every response is back
      drain();
      queue_session(count - count / 2);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      push_req(KIND_HELD, 16'h0000, 32'h0, 4'd0, 1'b0);
      push_req(KIND_POLL, 16'h0000, 32'h0, 4'd0, 1'b0);
      push_req(KIND_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 4'hF, 1'b1);
      push_req(KIND_SCAN, 16'hFFFF, 32'h0, 4'd0, 1'b0);
      push_req(KIND_HELD, 16'h0000, 32'h0, 4'd15, 1'b0);
      push_req(KIND_HELD, 16'h0000, 32'h0, 4'd15, 1'b1);
      push_req(KIND_HELD, 16'h0000, 32'h0, 4'd11, 1'b1);
      push_req(KIND_HELD, 16'h0000, 32'h0, 4'd0, 1'b1);
      push_req(KIND_POLL, 16'h0000, 32'd100, 4'd0, 1'b0);
      push_req(KIND_HELD, 16'h0000, 32'h0, 4'd0, 1'b0);
      push_req(KIND_POLL, 16'h0000, 32'd100, 4'd0, 1'b0);
      push_req(KIND_SCAN, 16'h8000, 32'h0, 4'd0, 1'b0);
      push_req(KIND_POLL, 16'h0000, 32'd200, 4'd0, 1'b0);
      push_req(KIND_POLL, 16'h0000, 32'd300, 4'd0, 1'b0);
      push_req(KIND_SCAN, 16'h0001, 32'h0, 4'd0, 1'b0);
      push_req(KIND_SCAN, 16'h0001, 32'h0, 4'd0, 1'b0);
      push_req(KIND_POLL, 16'h0000, 32'd1000, 4'd0, 1'b0);
      push_req(KIND_POLL, 16'h0000, 32'd1010, 4'd0, 1'b0);
      push_req(KIND_POLL, 16'h0000, 32'd1019, 4'd0, 1'b0);
      push_req(KIND_POLL, 16'h0000, 32'd1020, 4'd0, 1'b0);
      push_req(KIND_POLL, 16'h0000, 32'd1025, 4'd0, 1'b0);
      push_req(KIND_POLL, 16'h0000, 32'hFFFF_FFF0, 4'd0, 1'b0);
      push_req(KIND_POLL, 16'h0000, 32'hFFFF_FFFF, 4'd0, 1'b0);
      push_req(KIND_POLL, 16'h0000, 32'd3, 4'd0, 1'b0);
      push_req(KIND_POLL, 16'h0000, 32'd4, 4'd0, 1'b0);

      run_phase(8'd1, 8'd1, 0, 0, 260);
      run_phase(8'd255, 8'd255, 71, 0, 260);
      run_phase(SPAN_W'($urandom_range(255, 1)), SPAN_W'($urandom_range(255, 1)), 0, 71, 260);
      run_phase(8'd255, 8'd1, 35, 35, 260);
      run_phase(8'd1, 8'd255, 0, 0, 260);
      run_phase(SPAN_W'($urandom_range(255, 1)), SPAN_W'($urandom_range(255, 1)), 35, 35, 260);
      drain();
      repeat (8) @(posedge clock);

      $display("run covered %0d requests under %0d register writes, including reset values",
               accepted, csr_writes);
      $display("keys reported as pressed: %0d, held queries answered true: %0d",
               presses, held_hits);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
